// ----- rtl/core/url_pc_pkg.sv -----
// ----------------------------------------------------------------------------
// url_pc_pkg
// shared types, character constants and helpers of the url percent codec
// ----------------------------------------------------------------------------
package url_pc_pkg;

    localparam int FIFO_DEPTH = 4;

    localparam logic [7:0] CH_DASH    = 8'h2d;
    localparam logic [7:0] CH_UNDER   = 8'h5f;
    localparam logic [7:0] CH_DOT     = 8'h2e;
    localparam logic [7:0] CH_TILDE   = 8'h7e;
    localparam logic [7:0] CH_PLUS    = 8'h2b;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    // one queued command: either a single result or a three-byte escape
    typedef struct packed {
        logic [7:0] data;
        logic       triple;
        logic       valid;
        logic       bad;
        logic       last;
    } cmd_t;

    typedef struct packed {
        logic ok;
        logic [3:0] val;
    } hex_t;

    function automatic logic is_unreserved(input logic [7:0] c);
        logic r;
        r = ((c >= 8'h30) && (c <= 8'h39)) ||
            ((c >= 8'h61) && (c <= 8'h7a)) ||
            ((c >= 8'h41) && (c <= 8'h5a)) ||
            (c == CH_DASH) || (c == CH_UNDER) || (c == CH_DOT) || (c == CH_TILDE);
        return r;
    endfunction

    function automatic hex_t hex_value(input logic [7:0] c);
        hex_t r;
        logic [7:0] t;
        r = '0;
        t = 8'h00;
        if ((c >= 8'h30) && (c <= 8'h39))
        begin
            r.ok  = 1'b1;
            r.val = c[3:0];
        end
        else if ((c >= 8'h61) && (c <= 8'h66))
        begin
            t     = c - 8'h57;
            r.ok  = 1'b1;
            r.val = t[3:0];
        end
        else if ((c >= 8'h41) && (c <= 8'h46))
        begin
            t     = c - 8'h37;
            r.ok  = 1'b1;
            r.val = t[3:0];
        end
        return r;
    endfunction

    // lowercase hex digit for a nibble
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] r;
        if (n < 4'd10)
            r = 8'h30 + {4'h0, n};
        else
            r = 8'h57 + {4'h0, n};
        return r;
    endfunction

endpackage

// ----- rtl/core/url_pc_front.sv -----
// ----------------------------------------------------------------------------
// url_pc_front
// accepts input bytes, tracks decode escapes and issues result commands
// ----------------------------------------------------------------------------
module url_pc_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_wdata,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // in_byte
    input  logic               s_tlast,   // in_last
    output logic               push_valid,
    input  logic               push_ready,
    output url_pc_pkg::cmd_t   push_cmd
);

    typedef enum logic [1:0]
    {
        ESC_IDLE,
        ESC_FIRST,
        ESC_SECOND
    } esc_t;

    esc_t             phase_reg, phase_next;
    logic [3:0]       digit_reg, digit_next;
    logic             digit_ok_reg, digit_ok_next;
    logic             decode_mode_reg;
    logic             accept;
    logic             produce;
    url_pc_pkg::hex_t hv;
    url_pc_pkg::cmd_t cmd;

    assign s_tready = push_ready;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        hv            = url_pc_pkg::hex_value(s_tdata);
        phase_next    = phase_reg;
        digit_next    = digit_reg;
        digit_ok_next = digit_ok_reg;
        produce       = 1'b0;
        cmd           = '0;
        cmd.last      = s_tlast;
        if (!decode_mode_reg)
        begin
            phase_next    = ESC_IDLE;
            digit_next    = 4'h0;
            digit_ok_next = 1'b0;
            produce       = 1'b1;
            cmd.data      = s_tdata;
            cmd.valid     = 1'b1;
            cmd.triple    = !url_pc_pkg::is_unreserved(s_tdata);
        end
        else
        begin
            unique case (phase_reg)
                ESC_FIRST:
                begin
                    digit_ok_next = hv.ok;
                    digit_next    = hv.ok ? hv.val : 4'h0;
                    phase_next    = ESC_SECOND;
                    // escape cut short right after its first digit
                    if (s_tlast)
                    begin
                        produce   = 1'b1;
                        cmd.valid = hv.ok;
                        cmd.bad   = !hv.ok;
                        cmd.data  = hv.ok ? {4'h0, hv.val} : 8'h00;
                    end
                end
                ESC_SECOND:
                begin
                    produce    = 1'b1;
                    phase_next = ESC_IDLE;
                    if (digit_ok_reg)
                    begin
                        cmd.valid = 1'b1;
                        cmd.data  = hv.ok ? {digit_reg, hv.val} : {4'h0, digit_reg};
                    end
                    else
                    begin
                        cmd.bad = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = ESC_IDLE;
                    if (s_tdata == url_pc_pkg::CH_PLUS)
                    begin
                        produce   = 1'b1;
                        cmd.valid = 1'b1;
                        cmd.data  = url_pc_pkg::CH_SPACE;
                    end
                    else if (s_tdata == url_pc_pkg::CH_PERCENT)
                    begin
                        phase_next    = ESC_FIRST;
                        digit_next    = 4'h0;
                        digit_ok_next = 1'b0;
                        if (s_tlast)
                        begin
                            produce = 1'b1;
                            cmd.bad = 1'b1;
                        end
                    end
                    else
                    begin
                        produce   = 1'b1;
                        cmd.valid = 1'b1;
                        cmd.data  = s_tdata;
                    end
                end
            endcase
        end
        if (s_tlast)
        begin
            phase_next    = ESC_IDLE;
            digit_next    = 4'h0;
            digit_ok_next = 1'b0;
        end
    end

    assign push_valid = accept && produce;
    assign push_cmd   = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= ESC_IDLE;
            digit_reg       <= 4'h0;
            digit_ok_reg    <= 1'b0;
            decode_mode_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                decode_mode_reg <= cfg_wdata;
            if (accept)
            begin
                phase_reg    <= phase_next;
                digit_reg    <= digit_next;
                digit_ok_reg <= digit_ok_next;
            end
        end
    end

`ifndef SYNTH
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tlast) |=> (phase_reg == ESC_IDLE))
        else $error("escape state not idle after end of string");
    a_encode_push: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !decode_mode_reg) |-> push_valid)
        else $error("encoded byte produced no command");
    a_second_push: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && decode_mode_reg && (phase_reg == ESC_SECOND)) |-> push_valid)
        else $error("escape closed without a result");
`endif

endmodule

// ----- rtl/core/url_pc_fifo.sv -----
// ----------------------------------------------------------------------------
// url_pc_fifo
// short command queue between the front and the back
// ----------------------------------------------------------------------------
module url_pc_fifo
#(
    parameter int DEPTH = url_pc_pkg::FIFO_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  url_pc_pkg::cmd_t push_cmd,
    output logic             pop_valid,
    input  logic             pop_ready,
    output url_pc_pkg::cmd_t pop_cmd
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    url_pc_pkg::cmd_t entry_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        ((count_reg == '0) || (count_reg == CW'(DEPTH))) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers out of step with count");
`endif

endmodule

// ----- rtl/core/url_pc_back.sv -----
// ----------------------------------------------------------------------------
// url_pc_back
// expands queued commands into output results, three beats for an escape
// ----------------------------------------------------------------------------
module url_pc_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  url_pc_pkg::cmd_t cmd,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,   // out_byte
    output logic             m_tlast,   // run_last
    output logic [2:0]       m_tuser    // byte_valid, string_end, bad_escape
);

    typedef enum logic [1:0]
    {
        BEAT_FIRST,
        BEAT_HIGH,
        BEAT_LOW
    } beat_t;

    beat_t beat_reg, beat_next;
    logic  final_beat;
    logic  xfer;

    assign final_beat = !cmd.triple || (beat_reg == BEAT_LOW);
    assign m_tvalid   = cmd_valid;
    assign xfer       = m_tvalid && m_tready;
    assign cmd_ready  = xfer && final_beat;
    assign m_tlast    = final_beat;
    assign m_tuser    = {cmd.bad, cmd.last && final_beat, cmd.valid};

    always_comb
    begin
        m_tdata = cmd.data;
        if (cmd.triple)
        begin
            unique case (beat_reg)
                BEAT_HIGH: m_tdata = url_pc_pkg::hex_char(cmd.data[7:4]);
                BEAT_LOW:  m_tdata = url_pc_pkg::hex_char(cmd.data[3:0]);
                default:   m_tdata = url_pc_pkg::CH_PERCENT;
            endcase
        end
    end

    always_comb
    begin
        beat_next = beat_reg;
        if (xfer)
        begin
            if (final_beat)
                beat_next = BEAT_FIRST;
            else if (beat_reg == BEAT_FIRST)
                beat_next = BEAT_HIGH;
            else
                beat_next = BEAT_LOW;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            beat_reg <= BEAT_FIRST;
        else
            beat_reg <= beat_next;
    end

`ifndef SYNTH
    a_mid_escape: assert property (@(posedge clk) disable iff (!rst_n)
        (beat_reg != BEAT_FIRST) |-> (cmd_valid && cmd.triple))
        else $error("escape beat without an escape command at the head");
`endif

endmodule

// ----- rtl/core/url_percent_codec_top.sv -----
// ----------------------------------------------------------------------------
// url_percent_codec_top
// byte-stream url percent encoder and decoder
// ----------------------------------------------------------------------------
// usage:
//   the s_ channel takes one character per transfer, tlast on the final
//   character of a string. the m_ channel gives result characters; tlast
//   marks the last result of an input byte, tuser[1] the last of a string,
//   tuser[0] a carried character, tuser[2] a broken decode escape.
//   cfg_we/cfg_wdata set the mode (0 encode, 1 decode) while idle.
// timing:
//   a result is registered in the command queue before it reaches the output. the front takes one
//   byte per cycle while the command queue (FIFO_DEPTH entries) has room; the
//   back moves one result per cycle while m_tready is high, so an encoded escape
//   gives three results and a plain byte one. decode bytes that only open
//   or advance an escape produce no result.
// reset and stall:
//   reset empties the queue, clears the escape state and selects encode.
//   when the receiver stalls the queue fills and then s_tready drops; no
//   transfer is lost on either side.
// ----------------------------------------------------------------------------
module url_percent_codec_top
#(
    parameter int FIFO_DEPTH = url_pc_pkg::FIFO_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte
    input  logic       s_tlast,   // in_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte
    output logic       m_tlast,   // run_last
    output logic [2:0] m_tuser    // byte_valid, string_end, bad_escape
);

    logic             push_valid, push_ready;
    url_pc_pkg::cmd_t push_cmd;
    logic             pop_valid, pop_ready;
    url_pc_pkg::cmd_t pop_cmd;

    url_pc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    url_pc_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    url_pc_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (pop_valid),
        .cmd_ready (pop_ready),
        .cmd       (pop_cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// checks the url percent codec against a cycle-free model of its byte stream:
// directed encode and decode strings, escape corner cases, mode changes,
// random strings with bursty input and a stalling receiver, and a long
// output hold-off that fills the block and stalls its input
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;
    localparam int   SETTLE_CYCLES = 8;
    localparam int   TOTAL_ITEMS = 100;

    typedef enum logic [1:0]
    {
        ESC_IDLE,
        ESC_FIRST,
        ESC_SECOND,
        ESC_UNUSED
    } esc_phase_t;

    typedef struct packed
    {
        logic [7:0] ch;
        logic       valid;
        logic       run_end;
        logic       str_end;
        logic       bad;
    } char_res_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic       cfg_wdata = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic [2:0] m_tuser;

    // model state of the codec
    logic       mode_dec = MODE_ENCODE;
    esc_phase_t esc_phase = ESC_IDLE;
    logic [3:0] esc_digit = 4'h0;
    logic       esc_ok = 1'b0;

    char_res_t expected_chars[$];
    char_res_t got_res;
    char_res_t want_res;
    int        fail_count = 0;

    int tx_burst_left = 0;
    bit tx_nogap = 1'b0;
    int sent_items = 0;

    int rx_style = 0;
    int rx_cycle = 0;
    int rx_hold_req = 0;
    int rx_hold_left = 0;

    url_percent_codec_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // in_byte
        .s_tlast   (s_tlast),    // in_last
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // out_byte
        .m_tlast   (m_tlast),    // run_last
        .m_tuser   (m_tuser)     // byte_valid, string_end, bad_escape
    );

    always #6 clk = ~clk;

    // {ok, value} of a hex digit character
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        if ((c >= 8'h30) && (c <= 8'h39))
            return {1'b1, c[3:0]};
        if ((c >= 8'h61) && (c <= 8'h66))
            return {1'b1, 4'(c - 8'h57)};
        if ((c >= 8'h41) && (c <= 8'h46))
            return {1'b1, 4'(c - 8'h37)};
        return 5'h00;
    endfunction

    function automatic logic is_plain_char(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h7a)) ||
               ((c >= 8'h41) && (c <= 8'h5a)) ||
               (c == url_pc_pkg::CH_DASH) || (c == url_pc_pkg::CH_UNDER) ||
               (c == url_pc_pkg::CH_DOT) || (c == url_pc_pkg::CH_TILDE);
    endfunction

    function automatic logic [7:0] nibble_char(input logic [3:0] n);
        return (n < 4'd10) ? (8'h30 + 8'(n)) : (8'h57 + 8'(n));
    endfunction

    function automatic char_res_t make_res(input logic [7:0] b, input logic v,
                                           input logic bad);
        char_res_t r;
        r.ch      = v ? b : 8'h00;
        r.valid   = v;
        r.run_end = 1'b0;
        r.str_end = 1'b0;
        r.bad     = bad;
        return r;
    endfunction

    // works out the results of one accepted character and queues them
    task automatic predict_chars(input logic [7:0] c, input logic l);
        char_res_t  res[$];
        logic [4:0] h;
        int         k;
        h = hex_nibble(c);
        if (mode_dec == MODE_ENCODE)
        begin
            esc_phase = ESC_IDLE;
            esc_digit = 4'h0;
            esc_ok    = 1'b0;
            if (is_plain_char(c))
                res.push_back(make_res(c, 1'b1, 1'b0));
            else
            begin
                res.push_back(make_res(url_pc_pkg::CH_PERCENT, 1'b1, 1'b0));
                res.push_back(make_res(nibble_char(c[7:4]), 1'b1, 1'b0));
                res.push_back(make_res(nibble_char(c[3:0]), 1'b1, 1'b0));
            end
        end
        else
        begin
            case (esc_phase)
                ESC_FIRST:
                begin
                    esc_ok    = h[4];
                    esc_digit = h[3:0];
                    esc_phase = ESC_SECOND;
                    // string ends inside the escape
                    if (l)
                        res.push_back(esc_ok ? make_res({4'h0, esc_digit}, 1'b1, 1'b0)
                                             : make_res(8'h00, 1'b0, 1'b1));
                end
                ESC_SECOND:
                begin
                    if (esc_ok)
                        res.push_back(make_res(h[4] ? {esc_digit, h[3:0]} : {4'h0, esc_digit},
                                               1'b1, 1'b0));
                    else
                        res.push_back(make_res(8'h00, 1'b0, 1'b1));
                    esc_phase = ESC_IDLE;
                end
                default:
                begin
                    esc_phase = ESC_IDLE;
                    if (c == url_pc_pkg::CH_PLUS)
                        res.push_back(make_res(url_pc_pkg::CH_SPACE, 1'b1, 1'b0));
                    else if (c == url_pc_pkg::CH_PERCENT)
                    begin
                        esc_phase = ESC_FIRST;
                        esc_digit = 4'h0;
                        esc_ok    = 1'b0;
                        if (l)
                            res.push_back(make_res(8'h00, 1'b0, 1'b1));
                    end
                    else
                        res.push_back(make_res(c, 1'b1, 1'b0));
                end
            endcase
        end
        if (l)
        begin
            esc_phase = ESC_IDLE;
            esc_digit = 4'h0;
            esc_ok    = 1'b0;
        end
        if (res.size() > 0)
        begin
            k = res.size() - 1;
            res[k].run_end = 1'b1;
            res[k].str_end = l;
        end
        foreach (res[i])
            expected_chars.push_back(res[i]);
    endtask

    // offers one character, with bursts and gaps, and waits for its transfer
    task automatic send_char(input logic [7:0] c, input logic l);
        int gap;
        gap = 0;
        if (tx_burst_left == 0)
        begin
            tx_burst_left = $urandom_range(1, 12);
            if (!tx_nogap && ($urandom_range(0, 3) != 0))
                gap = $urandom_range(1, 6);
        end
        tx_burst_left--;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= l;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_chars(c, l);
        sent_items++;
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic v);
        wait_drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        mode_dec = v;
    endtask

    function automatic logic [7:0] rand_hex_char();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10)
            return 8'(8'h30 + v);
        return 8'(($urandom_range(0, 1) ? 8'h37 : 8'h57) + v);
    endfunction

    function automatic logic [7:0] rand_nonhex_char();
        logic [7:0] c;
        logic [4:0] h;
        c = url_pc_pkg::CH_PERCENT;
        h = 5'h1f;
        while (h[4])
        begin
            c = 8'($urandom_range(0, 255));
            h = hex_nibble(c);
        end
        return c;
    endfunction

    function automatic logic [7:0] rand_plain_char();
        case ($urandom_range(0, 4))
            0: return 8'(8'h30 + $urandom_range(0, 9));
            1: return 8'(8'h61 + $urandom_range(0, 25));
            2: return 8'(8'h41 + $urandom_range(0, 25));
            3: return ($urandom_range(0, 1)) ? url_pc_pkg::CH_DASH : url_pc_pkg::CH_UNDER;
            default: return ($urandom_range(0, 1)) ? url_pc_pkg::CH_DOT : url_pc_pkg::CH_TILDE;
        endcase
    endfunction

    task automatic send_buf(input logic [7:0] buf_q[$]);
        foreach (buf_q[i])
            send_char(buf_q[i], i == buf_q.size() - 1);
    endtask

    task automatic rand_encode_string();
        logic [7:0] buf_q[$];
        int         n;
        n = $urandom_range(1, 8);
        repeat (n)
            buf_q.push_back($urandom_range(0, 1) ? rand_plain_char()
                                                 : 8'($urandom_range(0, 255)));
        send_buf(buf_q);
    endtask

    // mostly well-formed escapes with random content, some broken or cut short
    task automatic rand_decode_string();
        logic [7:0] buf_q[$];
        logic [7:0] c;
        int         n;
        int         kind;
        n = $urandom_range(1, 6);
        repeat (n)
        begin
            kind = $urandom_range(0, 11);
            if (kind < 3)
            begin
                c = 8'($urandom_range(0, 255));
                buf_q.push_back((c == url_pc_pkg::CH_PERCENT) ? url_pc_pkg::CH_PLUS : c);
            end
            else if (kind == 3)
                buf_q.push_back(url_pc_pkg::CH_PLUS);
            else if (kind < 9)
            begin
                buf_q.push_back(url_pc_pkg::CH_PERCENT);
                buf_q.push_back(rand_hex_char());
                buf_q.push_back(rand_hex_char());
            end
            else if (kind == 9)
            begin
                buf_q.push_back(url_pc_pkg::CH_PERCENT);
                buf_q.push_back(rand_nonhex_char());
                buf_q.push_back(8'($urandom_range(0, 255)));
            end
            else if (kind == 10)
            begin
                buf_q.push_back(url_pc_pkg::CH_PERCENT);
                buf_q.push_back(rand_hex_char());
                buf_q.push_back(rand_nonhex_char());
            end
            else
                buf_q.push_back(8'($urandom_range(0, 255)));
        end
        // escape cut short by the end of the string
        if ($urandom_range(0, 4) == 0)
        begin
            buf_q.push_back(url_pc_pkg::CH_PERCENT);
            if ($urandom_range(0, 1))
                buf_q.push_back($urandom_range(0, 1) ? rand_hex_char() : rand_nonhex_char());
        end
        send_buf(buf_q);
    endtask

    task automatic test_encode_directed();
        write_mode(MODE_ENCODE);
        send_char(8'h00, 1'b0);
        send_char(8'hff, 1'b0);
        send_char(8'h61, 1'b0);
        send_char(8'h5a, 1'b0);
        send_char(8'h39, 1'b1);
        send_char(url_pc_pkg::CH_DASH, 1'b0);
        send_char(url_pc_pkg::CH_TILDE, 1'b0);
        send_char(8'h2f, 1'b1);
    endtask

    task automatic test_decode_directed();
        write_mode(MODE_DECODE);
        send_char(url_pc_pkg::CH_PLUS, 1'b0);
        send_char(8'hff, 1'b0);
        send_char(url_pc_pkg::CH_PERCENT, 1'b0);
        send_char(8'h61, 1'b0);
        send_char(8'h46, 1'b0);
        // second byte not a hex digit
        send_char(url_pc_pkg::CH_PERCENT, 1'b0);
        send_char(8'h34, 1'b0);
        send_char(8'h67, 1'b0);
        // no leading hex digit
        send_char(url_pc_pkg::CH_PERCENT, 1'b0);
        send_char(8'h7a, 1'b0);
        send_char(8'h31, 1'b1);
        // cut short after a parsed digit, after a bad digit, and on the percent
        send_char(url_pc_pkg::CH_PERCENT, 1'b0);
        send_char(8'h37, 1'b1);
        send_char(url_pc_pkg::CH_PERCENT, 1'b0);
        send_char(8'h7a, 1'b1);
        send_char(url_pc_pkg::CH_PERCENT, 1'b1);
    endtask

    // an encode step between two decode steps drops the pending escape
    task automatic test_mode_change();
        write_mode(MODE_DECODE);
        send_char(url_pc_pkg::CH_PERCENT, 1'b0);
        send_char(8'h34, 1'b0);
        write_mode(MODE_ENCODE);
        send_char(8'h21, 1'b0);
        write_mode(MODE_DECODE);
        send_char(8'h31, 1'b1);
    endtask

    task automatic test_random();
        int n;
        while (sent_items < TOTAL_ITEMS)
        begin
            write_mode(1'($urandom_range(0, 1)));
            n = $urandom_range(1, 4);
            repeat (n)
            begin
                if (mode_dec == MODE_DECODE)
                    rand_decode_string();
                else
                    rand_encode_string();
            end
        end
    endtask

    // receiver holds off while the sender keeps offering expanding bytes, then decode escapes
    task automatic test_backpressure();
        write_mode(MODE_ENCODE);
        tx_nogap = 1'b1;
        rx_hold_req = 60;
        repeat (20)
            send_char(8'($urandom_range(128, 255)), 1'($urandom_range(0, 1)));
        tx_nogap = 1'b0;
        wait_drain();
        write_mode(MODE_DECODE);
        tx_nogap = 1'b1;
        rx_hold_req = 60;
        repeat (4)
        begin
            send_char(url_pc_pkg::CH_PERCENT, 1'b0);
            send_char(rand_hex_char(), 1'b0);
            send_char(rand_hex_char(), 1'b0);
            send_char(url_pc_pkg::CH_PLUS, 1'b0);
        end
        send_char(8'h41, 1'b1);
        tx_nogap = 1'b0;
        wait_drain();
    endtask

    // receiver stall pattern, with a counted hold-off on request
    always @(posedge clk)
    begin
        if (rx_cycle == 0)
        begin
            rx_style = $urandom_range(0, 3);
            rx_cycle = $urandom_range(8, 40);
        end
        rx_cycle--;
        if (rx_hold_req > 0)
        begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (rx_hold_left > 0)
        begin
            rx_hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            case (rx_style)
                0: m_tready <= 1'b1;
                1: m_tready <= $urandom_range(0, 1);
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // compares every output transfer with the oldest expected result
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_res = {m_tdata, m_tuser[0], m_tlast, m_tuser[1], m_tuser[2]};
            if (expected_chars.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h v%b rl%b se%b be%b",
                         $time, got_res.ch, got_res.valid, got_res.run_end,
                         got_res.str_end, got_res.bad);
                fail_count++;
            end
            else
            begin
                want_res = expected_chars.pop_front();
                if (got_res !== want_res)
                begin
                    $display("%0t: mismatch, expected %h %b%b%b%b, actual %h %b%b%b%b",
                             $time, want_res.ch, want_res.valid, want_res.run_end,
                             want_res.str_end, want_res.bad, got_res.ch, got_res.valid,
                             got_res.run_end, got_res.str_end, got_res.bad);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_encode_directed();
        test_decode_directed();
        test_mode_change();
        test_backpressure();
        test_random();
        wait_drain();
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
